// ===== sv/mfcr_pkg.sv =====
package mfcr_pkg;

  localparam int unsigned MAX_FRAME    = 240;
  localparam int unsigned MIN_FRAME    = 16;
  localparam int unsigned HEADER_BYTES = 10;

  localparam logic [7:0] MAGIC0        = 8'h48;  // 'H'
  localparam logic [7:0] MAGIC1        = 8'h32;  // '2'
  localparam logic [7:0] FRAME_VERSION = 8'h01;

  localparam logic [7:0] POS_MAGIC0  = 8'd0;
  localparam logic [7:0] POS_MAGIC1  = 8'd1;
  localparam logic [7:0] POS_VERSION = 8'd2;
  localparam logic [7:0] POS_TYPE    = 8'd3;
  localparam logic [7:0] POS_SEQ_LO  = 8'd4;
  localparam logic [7:0] POS_SEQ_HI  = 8'd5;
  localparam logic [7:0] POS_CRC_LO  = 8'd6;
  localparam logic [7:0] POS_CRC_HI  = 8'd7;
  localparam logic [7:0] POS_RSSI    = 8'd8;
  localparam logic [7:0] POS_SNR     = 8'd9;
  localparam logic [7:0] POS_MAX     = 8'hFF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] EXP_TYPE_RST   = 8'd1;
  localparam logic [7:0] REPLY_TYPE_RST = 8'd2;

  localparam logic REG_EXPECTED_TYPE = 1'b0;
  localparam logic REG_REPLY_TYPE    = 1'b1;

  // per-word status handed from the frame checker to the output stage
  typedef struct packed {
    logic [7:0]  pos;
    logic        frame_ok;
    logic [15:0] sequence_res;
  } chk_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/mfcr_link_enc.sv =====
module mfcr_link_enc
  import mfcr_pkg::*;
(
  input  logic signed [10:0] rssi_quarter_dbm,
  input  logic signed [10:0] snr_quarter_db,
  output logic [7:0]         rssi_code,
  output logic [7:0]         snr_code
);

  logic [11:0]        q_ext;
  logic [11:0]        mag;
  logic [11:0]        rnd;
  logic [9:0]         rm;
  logic signed [11:0] r;

  // round half away from zero on the magnitude, then offset by 200
  assign q_ext = 12'(rssi_quarter_dbm);
  assign mag   = rssi_quarter_dbm[10] ? (~q_ext + 12'd1) : q_ext;
  assign rnd   = mag + 12'd2;
  assign rm    = rnd[11:2];
  assign r     = rssi_quarter_dbm[10] ? (12'sd200 - $signed({2'b00, rm}))
                                      : (12'sd200 + $signed({2'b00, rm}));

  always_comb begin
    if (r < 12'sd0) begin
      rssi_code = 8'd0;
    end else if (r > 12'sd255) begin
      rssi_code = 8'd255;
    end else begin
      rssi_code = r[7:0];
    end
  end

  always_comb begin
    if (snr_quarter_db < -11'sd128) begin
      snr_code = 8'h80;
    end else if (snr_quarter_db > 11'sd127) begin
      snr_code = 8'h7F;
    end else begin
      snr_code = snr_quarter_db[7:0];
    end
  end

endmodule

// ===== sv/mfcr_frame_check.sv =====
module mfcr_frame_check
  import mfcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] in_byte,
  input  logic       last,
  input  logic [7:0] expected_type,
  output chk_t       chk
);

  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] carried_r, carried_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [8:0]  len;
  logic        len_ok;

  always_comb begin
    hdr_good_nxt = hdr_good_r;
    seq_nxt      = seq_r;
    carried_nxt  = carried_r;
    case (pos_r)
      POS_MAGIC0:  if (in_byte != MAGIC0) hdr_good_nxt = 1'b0;
      POS_MAGIC1:  if (in_byte != MAGIC1) hdr_good_nxt = 1'b0;
      POS_VERSION: if (in_byte != FRAME_VERSION) hdr_good_nxt = 1'b0;
      POS_TYPE:    if (in_byte != expected_type) hdr_good_nxt = 1'b0;
      POS_SEQ_LO:  seq_nxt[7:0] = in_byte;
      POS_SEQ_HI:  seq_nxt[15:8] = in_byte;
      POS_CRC_LO:  carried_nxt[7:0] = in_byte;
      POS_CRC_HI:  carried_nxt[15:8] = in_byte;
      default: ;
    endcase
  end

  assign crc_nxt = (pos_r >= 8'(HEADER_BYTES)) ? crc16_byte(crc_r, in_byte) : crc_r;
  assign pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 8'd1;

  assign len    = {1'b0, pos_r} + 9'd1;
  assign len_ok = (len >= 9'(MIN_FRAME)) && (len <= 9'(MAX_FRAME));

  assign chk.pos          = pos_r;
  assign chk.frame_ok     = last && len_ok && hdr_good_nxt && (crc_nxt == carried_nxt);
  assign chk.sequence_res = last ? seq_nxt : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 8'd0;
      crc_r      <= CRC_INIT;
      carried_r  <= 16'd0;
      hdr_good_r <= 1'b1;
      seq_r      <= 16'd0;
    end else if (adv) begin
      if (last) begin
        pos_r      <= 8'd0;
        crc_r      <= CRC_INIT;
        carried_r  <= 16'd0;
        hdr_good_r <= 1'b1;
        seq_r      <= 16'd0;
      end else begin
        pos_r      <= pos_nxt;
        crc_r      <= crc_nxt;
        carried_r  <= carried_nxt;
        hdr_good_r <= hdr_good_nxt;
        seq_r      <= seq_nxt;
      end
    end
  end

  // CRC only starts moving once payload bytes come in
  a_crc_idle_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= 8'(HEADER_BYTES)) |-> (crc_r == CRC_INIT))
    else $error("crc changed inside header");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |=> (pos_r == 8'd0))
    else $error("position not cleared after last word");

  a_frame_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == 8'd0) |-> (hdr_good_r && seq_r == 16'd0 && carried_r == 16'd0))
    else $error("frame state dirty at frame start");

endmodule

// ===== sv/measurement_frame_checker_responder.sv =====
// Path: an accepted input word is held in the input register, then the reply word built
// from it is registered in the output register, which drives the output port.
// Throughput: one word per cycle; while a reply waits for out_tready the input register
// takes one more word, then in_tready drops until the reply is taken.
// Reset (rst_n low, synchronous): pipeline emptied, frame state cleared,
// expected_type back to 1 and reply_type back to 2.
module measurement_frame_checker_responder
  import mfcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // in_byte[7:0], rssi_quarter_dbm[18:8], snr_quarter_db[29:19]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_byte[7:0], sequence_res[23:8]
  output logic        out_tlast,
  output logic        out_tuser,  // frame_ok[0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]         expected_type_r;
  logic [7:0]         reply_type_r;

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_last_r;
  logic signed [10:0] s1_rssi_r;
  logic signed [10:0] s1_snr_r;
  logic               s1_adv;
  logic               s1_fire;

  logic               out_valid_r;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r;
  logic               out_ok_r;
  logic [15:0]        out_seq_r;

  logic [7:0]         rssi_code;
  logic [7:0]         snr_code;
  chk_t               chk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_type_r <= EXP_TYPE_RST;
      reply_type_r    <= REPLY_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPECTED_TYPE: expected_type_r <= cfg_wdata;
        REG_REPLY_TYPE:    reply_type_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata[7:0];
      s1_last_r <= in_tlast;
      s1_rssi_r <= $signed(in_tdata[18:8]);
      s1_snr_r  <= $signed(in_tdata[29:19]);
    end
  end

  mfcr_link_enc u_link_enc (
    .rssi_quarter_dbm (s1_rssi_r),
    .snr_quarter_db   (s1_snr_r),
    .rssi_code        (rssi_code),
    .snr_code         (snr_code)
  );

  mfcr_frame_check u_frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (s1_fire),
    .in_byte       (s1_byte_r),
    .last          (s1_last_r),
    .expected_type (expected_type_r),
    .chk           (chk)
  );

  always_comb begin
    case (chk.pos)
      POS_TYPE: out_byte_nxt = reply_type_r;
      POS_RSSI: out_byte_nxt = rssi_code;
      POS_SNR:  out_byte_nxt = snr_code;
      default:  out_byte_nxt = s1_byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= s1_last_r;
      out_ok_r   <= chk.frame_ok;
      out_seq_r  <= chk.sequence_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_seq_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ok_r;

  a_ok_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame_ok set on a word that is not last");

  a_seq_zero_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[23:8] == 16'd0))
    else $error("sequence reported before last word");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r)))
    else $error("input stage lost a word while stalled");

endmodule
